>>> hw/rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int COUNT_W = $clog2(MAX_NODES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ETOT_W  = $clog2(MAX_EDGES + 1);

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_F_ROOT,
        ST_SCAN,
        ST_CHECK,
        ST_POP,
        ST_R_ROOT,
        ST_R_LOAD,
        ST_EMIT
    } t_state;

    // Write request into the edge store
    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic              clear;
    } t_edge_req;

endpackage

>>> hw/rtl/lsc_edge_store.sv
`timescale 1ns / 1ps

module lsc_edge_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lsc_pkg::t_edge_req              i_req,
    input  logic [lsc_pkg::COUNT_W-1:0]     i_node_lim,
    input  logic [lsc_pkg::EADDR_W-1:0]     i_rd_addr,
    output logic [lsc_pkg::NODE_W-1:0]      o_rd_from,
    output logic [lsc_pkg::NODE_W-1:0]      o_rd_to,
    output logic [lsc_pkg::ETOT_W-1:0]      o_total,
    output logic                            o_dropped
);

    logic [lsc_pkg::NODE_W-1:0] mem_from [lsc_pkg::MAX_EDGES];
    logic [lsc_pkg::NODE_W-1:0] mem_to   [lsc_pkg::MAX_EDGES];
    logic [lsc_pkg::ETOT_W-1:0] r_total;
    logic                       r_drop;
    logic                       keep;

    // Accept the edge only with room left and both ends in range
    assign keep = (r_total != lsc_pkg::ETOT_W'(lsc_pkg::MAX_EDGES))
                  && ({1'b0, i_req.src} < i_node_lim)
                  && ({1'b0, i_req.dst} < i_node_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_drop  <= 1'b0;
        end else if (i_req.clear) begin
            r_total <= '0;
            r_drop  <= 1'b0;
        end else if (i_req.wr_en) begin
            if (keep) begin
                r_total <= r_total + 1'b1;
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Edge memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && keep) begin
            mem_from[r_total[lsc_pkg::EADDR_W-1:0]] <= i_req.src;
            mem_to[r_total[lsc_pkg::EADDR_W-1:0]]   <= i_req.dst;
        end
        o_rd_from <= mem_from[i_rd_addr];
        o_rd_to   <= mem_to[i_rd_addr];
    end

    assign o_total   = r_total;
    assign o_dropped = r_drop;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= lsc_pkg::ETOT_W'(lsc_pkg::MAX_EDGES))
        else $error("edge count beyond capacity");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clear |=> (r_total == '0) && !r_drop)
        else $error("edge store not cleared");
    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop && !i_req.clear |=> r_drop)
        else $error("drop flag lost");
`endif

endmodule

>>> hw/rtl/largest_strong_component.sv
`timescale 1ns / 1ps

// Largest strongly connected component finder.
// Input stream: s_axis tuser carries the command (0 add edge, 1 run), tdata
// carries src_node [5:0] and dst_node [11:6]. Edges past 256 or with an endpoint
// at or above node_count are dropped and flagged. A run performs Kosaraju's two
// depth-first passes with one edge compare unit scanning the edge memory: each
// edge examined takes a registered memory read, then a compare. s_axis tready
// is low during a run. Results leave on m_axis, one member per transfer in
// ascending order, tlast on the final member, tdata = member [5:0], size [12:6],
// dropped [13]. A stalled receiver holds the output register and pauses the
// emit scan. The user must write the node_count register over the cfg channel
// (always ready) only while the block is idle; the block does not enforce it.
// Reset clears the edge store, flags and node_count to 64.
module largest_strong_component (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // src_node [5:0], dst_node [11:6]
    input  logic [0:0]  s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // member_node [5:0], component_size [12:6],
                                        // edges_dropped [13]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int NW = lsc_pkg::NODE_W;
    localparam int CW = lsc_pkg::COUNT_W;
    localparam int TW = lsc_pkg::ETOT_W;

    lsc_pkg::t_state r_state, n_state;

    logic [6:0]            r_node_cfg;
    logic [CW-1:0]         node_lim;
    logic                  r_rev, n_rev;
    logic [CW-1:0]         r_root, n_root;
    logic [CW-1:0]         r_fcnt, n_fcnt;
    logic [CW-1:0]         r_k, n_k;
    logic [NW-1:0]         r_top_v, n_top_v;
    logic [TW-1:0]         r_top_c, n_top_c;
    logic [CW-1:0]         r_sp, n_sp;
    logic [lsc_pkg::MAX_NODES-1:0] r_seen_f, n_seen_f;
    logic [lsc_pkg::MAX_NODES-1:0] r_seen_r, n_seen_r;
    logic [lsc_pkg::MAX_NODES-1:0] r_grp, n_grp;
    logic [lsc_pkg::MAX_NODES-1:0] r_best, n_best;
    logic [CW-1:0]         r_gcnt, n_gcnt;
    logic [CW-1:0]         r_best_size, n_best_size;
    logic [NW-1:0]         r_scan, n_scan;
    logic [CW-1:0]         r_emit_cnt, n_emit_cnt;

    logic                  r_out_valid, n_out_valid;
    logic [NW-1:0]         r_out_node, n_out_node;
    logic [CW-1:0]         r_out_size, n_out_size;
    logic                  r_out_last, n_out_last;
    logic                  r_out_drop, n_out_drop;

    // Walk stack and finish order memories
    logic [NW+TW-1:0]      stack_mem [lsc_pkg::MAX_NODES];
    logic [NW-1:0]         fin_mem   [lsc_pkg::MAX_NODES];
    logic [NW+TW-1:0]      r_stack_q;
    logic [NW-1:0]         r_fin_q;
    logic                  stack_we, fin_we;
    logic [NW-1:0]         stack_waddr, stack_raddr, fin_raddr;
    logic [NW+TW-1:0]      stack_wdata;

    lsc_pkg::t_edge_req    edge_req;
    logic [NW-1:0]         e_from, e_to, edge_a, edge_b;
    logic [TW-1:0]         e_total;
    logic                  e_drop;
    logic                  in_xfer;
    logic                  out_free;
    logic                  hit;

    // Clamp node count into 1..MAX_NODES
    always_comb begin
        if (r_node_cfg == '0) begin
            node_lim = CW'(1);
        end else if (r_node_cfg > 7'(lsc_pkg::MAX_NODES)) begin
            node_lim = CW'(lsc_pkg::MAX_NODES);
        end else begin
            node_lim = CW'(r_node_cfg);
        end
    end

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cfg <= 7'(lsc_pkg::MAX_NODES);
        end else if (i_cfg_valid) begin
            r_node_cfg <= i_cfg_data;
        end
    end

    assign s_axis_tready = (r_state == lsc_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    lsc_edge_store u_edges (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (edge_req),
        .i_node_lim (node_lim),
        .i_rd_addr  (r_top_c[lsc_pkg::EADDR_W-1:0]),
        .o_rd_from  (e_from),
        .o_rd_to    (e_to),
        .o_total    (e_total),
        .o_dropped  (e_drop)
    );

    // Orient the edge for the current pass
    assign edge_a = r_rev ? e_to : e_from;
    assign edge_b = r_rev ? e_from : e_to;
    assign hit = (edge_a == r_top_v) && ({1'b0, edge_a} < node_lim)
                 && ({1'b0, edge_b} < node_lim)
                 && !(r_rev ? r_seen_r[edge_b] : r_seen_f[edge_b]);

    assign stack_raddr = NW'(r_sp - 1'b1);
    assign fin_raddr   = NW'(r_k - 1'b1);

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_rev       = r_rev;
        n_root      = r_root;
        n_fcnt      = r_fcnt;
        n_k         = r_k;
        n_top_v     = r_top_v;
        n_top_c     = r_top_c;
        n_sp        = r_sp;
        n_seen_f    = r_seen_f;
        n_seen_r    = r_seen_r;
        n_grp       = r_grp;
        n_best      = r_best;
        n_gcnt      = r_gcnt;
        n_best_size = r_best_size;
        n_scan      = r_scan;
        n_emit_cnt  = r_emit_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_node  = r_out_node;
        n_out_size  = r_out_size;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        edge_req.wr_en = 1'b0;
        edge_req.src   = s_axis_tdata[NW-1:0];
        edge_req.dst   = s_axis_tdata[2*NW-1:NW];
        edge_req.clear = 1'b0;
        stack_we    = 1'b0;
        stack_waddr = r_sp[NW-1:0];
        stack_wdata = {r_top_v, r_top_c + 1'b1};
        fin_we      = 1'b0;

        case (r_state)
            lsc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser[0] == lsc_pkg::CMD_ADD_EDGE) begin
                        edge_req.wr_en = 1'b1;
                    end else begin
                        n_seen_f    = '0;
                        n_seen_r    = '0;
                        n_best_size = '0;
                        n_fcnt      = '0;
                        n_root      = '0;
                        n_sp        = '0;
                        n_rev       = 1'b0;
                        n_state     = lsc_pkg::ST_F_ROOT;
                    end
                end
            end
            lsc_pkg::ST_F_ROOT: begin
                if (r_root >= node_lim) begin
                    n_k     = r_fcnt;
                    n_rev   = 1'b1;
                    n_state = lsc_pkg::ST_R_ROOT;
                end else if (r_seen_f[r_root[NW-1:0]]) begin
                    n_root = r_root + 1'b1;
                end else begin
                    n_top_v = r_root[NW-1:0];
                    n_top_c = '0;
                    n_sp    = '0;
                    n_seen_f[r_root[NW-1:0]] = 1'b1;
                    n_state = lsc_pkg::ST_SCAN;
                end
            end
            lsc_pkg::ST_SCAN: begin
                if (r_top_c == e_total) begin
                    // Node exhausted: retire it
                    if (!r_rev) begin
                        fin_we = 1'b1;
                        n_fcnt = r_fcnt + 1'b1;
                    end
                    if (r_sp == '0) begin
                        if (!r_rev) begin
                            n_root  = r_root + 1'b1;
                            n_state = lsc_pkg::ST_F_ROOT;
                        end else begin
                            if (r_gcnt > r_best_size) begin
                                n_best_size = r_gcnt;
                                n_best      = r_grp;
                            end
                            n_state = lsc_pkg::ST_R_ROOT;
                        end
                    end else begin
                        n_state = lsc_pkg::ST_POP;
                    end
                end else begin
                    n_state = lsc_pkg::ST_CHECK;
                end
            end
            lsc_pkg::ST_CHECK: begin
                if (hit) begin
                    // Descend: save parent with advanced cursor
                    stack_we = 1'b1;
                    n_sp     = r_sp + 1'b1;
                    n_top_v  = edge_b;
                    n_top_c  = '0;
                    if (r_rev) begin
                        n_seen_r[edge_b] = 1'b1;
                        n_grp[edge_b]    = 1'b1;
                        n_gcnt           = r_gcnt + 1'b1;
                    end else begin
                        n_seen_f[edge_b] = 1'b1;
                    end
                end else begin
                    n_top_c = r_top_c + 1'b1;
                end
                n_state = lsc_pkg::ST_SCAN;
            end
            lsc_pkg::ST_POP: begin
                n_top_v = r_stack_q[NW+TW-1:TW];
                n_top_c = r_stack_q[TW-1:0];
                n_sp    = r_sp - 1'b1;
                n_state = lsc_pkg::ST_SCAN;
            end
            lsc_pkg::ST_R_ROOT: begin
                if (r_k == '0) begin
                    n_scan     = '0;
                    n_emit_cnt = '0;
                    n_state    = lsc_pkg::ST_EMIT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = lsc_pkg::ST_R_LOAD;
                end
            end
            lsc_pkg::ST_R_LOAD: begin
                if (r_seen_r[r_fin_q]) begin
                    n_state = lsc_pkg::ST_R_ROOT;
                end else begin
                    n_top_v = r_fin_q;
                    n_top_c = '0;
                    n_sp    = '0;
                    n_seen_r[r_fin_q] = 1'b1;
                    n_grp   = '0;
                    n_grp[r_fin_q] = 1'b1;
                    n_gcnt  = CW'(1);
                    n_state = lsc_pkg::ST_SCAN;
                end
            end
            lsc_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_scan = r_scan + 1'b1;
                    if (r_best[r_scan]) begin
                        n_out_valid = 1'b1;
                        n_out_node  = r_scan;
                        n_out_size  = r_best_size;
                        n_out_drop  = e_drop;
                        n_out_last  = (r_emit_cnt + 1'b1 == r_best_size);
                        n_emit_cnt  = r_emit_cnt + 1'b1;
                        if (r_emit_cnt + 1'b1 == r_best_size) begin
                            edge_req.clear = 1'b1;
                            n_state        = lsc_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_best_size <= '0;
            r_seen_f    <= '0;
            r_seen_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_best_size <= n_best_size;
            r_seen_f    <= n_seen_f;
            r_seen_r    <= n_seen_r;
        end
    end

    // Walk datapath and output payload
    always_ff @(posedge i_clk) begin
        r_rev      <= n_rev;
        r_root     <= n_root;
        r_fcnt     <= n_fcnt;
        r_k        <= n_k;
        r_top_v    <= n_top_v;
        r_top_c    <= n_top_c;
        r_sp       <= n_sp;
        r_grp      <= n_grp;
        r_best     <= n_best;
        r_gcnt     <= n_gcnt;
        r_scan     <= n_scan;
        r_emit_cnt <= n_emit_cnt;
        r_out_node <= n_out_node;
        r_out_size <= n_out_size;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    // Stack and finish order memories
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (fin_we) begin
            fin_mem[r_fcnt[NW-1:0]] <= r_top_v;
        end
        r_stack_q <= stack_mem[stack_raddr];
        r_fin_q   <= fin_mem[fin_raddr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_drop, r_out_size, r_out_node};

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != lsc_pkg::ST_IDLE |-> r_sp < CW'(lsc_pkg::MAX_NODES))
        else $error("walk stack overflow");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_EMIT |-> r_best_size != '0)
        else $error("emit with empty component");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_EMIT |-> r_emit_cnt < r_best_size)
        else $error("emitted more members than component size");
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_R_ROOT |-> r_fcnt <= node_lim)
        else $error("finish order longer than node count");
`endif

endmodule

>>> verif/tb_largest_strong_component.sv
`timescale 1ns / 1ps

module tb_largest_strong_component;

    typedef struct packed {
        logic       cmd;
        logic [5:0] src;
        logic [5:0] dst;
    } t_edge_item;

    typedef struct packed {
        logic [5:0] member;
        logic [6:0] size;
        logic       last;
        logic       dropped;
    } t_member;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    largest_strong_component uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state
    logic [5:0]  pm_from [lsc_pkg::MAX_EDGES];
    logic [5:0]  pm_to   [lsc_pkg::MAX_EDGES];
    int          pm_total;
    logic        pm_drop;
    logic [6:0]  pm_nodes;
    logic [63:0] pm_seen;
    logic [5:0]  pm_finish [lsc_pkg::MAX_NODES];
    int          pm_fcount;
    logic [5:0]  pm_group [lsc_pkg::MAX_NODES];
    logic [5:0]  pm_stack_node [lsc_pkg::MAX_NODES];
    int          pm_stack_cur [lsc_pkg::MAX_NODES];

    t_edge_item  pending_items[$];
    t_member     expected_members[$];

    int  mismatches = 0;
    int  members_seen = 0;
    int  runs_sent = 0;
    int  items_accepted = 0;
    int  hold_cycles = 0;
    bit  stall_on = 0;
    bit  rx_ready_pick;
    bit  tx_done = 0;

    function automatic int eff_nodes();
        if (pm_nodes == 0) return 1;
        if (pm_nodes > lsc_pkg::MAX_NODES) return lsc_pkg::MAX_NODES;
        return pm_nodes;
    endfunction

    // Iterative depth-first walk; fills group on the reverse pass
    function automatic int dfs_walk(int start, int n, bit rev);
        int depth;
        int gcount;
        int v;
        int c;
        int a;
        int b;
        bit pushed;
        depth = 1;
        gcount = 0;
        pm_seen[start] = 1'b1;
        pm_stack_node[0] = start[5:0];
        pm_stack_cur[0] = 0;
        if (rev) begin
            pm_group[gcount] = start[5:0];
            gcount++;
        end
        while (depth > 0) begin
            v = pm_stack_node[depth-1];
            c = pm_stack_cur[depth-1];
            pushed = 0;
            while (c < pm_total) begin
                a = rev ? pm_to[c] : pm_from[c];
                b = rev ? pm_from[c] : pm_to[c];
                c++;
                if (a == v && a < n && b < n && !pm_seen[b]) begin
                    pm_stack_cur[depth-1] = c;
                    pm_seen[b] = 1'b1;
                    if (depth < lsc_pkg::MAX_NODES) begin
                        pm_stack_node[depth] = b[5:0];
                        pm_stack_cur[depth] = 0;
                        depth++;
                    end
                    if (rev && gcount < lsc_pkg::MAX_NODES) begin
                        pm_group[gcount] = b[5:0];
                        gcount++;
                    end
                    pushed = 1;
                    break;
                end
            end
            if (!pushed) begin
                depth--;
                if (!rev && pm_fcount < lsc_pkg::MAX_NODES) begin
                    pm_finish[pm_fcount] = v[5:0];
                    pm_fcount++;
                end
            end
        end
        return gcount;
    endfunction

    // Apply one accepted item and queue the component members it produces
    task automatic predict_component(t_edge_item it);
        int n;
        int g;
        int best;
        logic [63:0] rseen;
        logic [63:0] best_set;
        t_member m;
        n = eff_nodes();
        if (it.cmd == lsc_pkg::CMD_ADD_EDGE) begin
            if (pm_total >= lsc_pkg::MAX_EDGES || it.src >= n || it.dst >= n) begin
                pm_drop = 1'b1;
            end else begin
                pm_from[pm_total] = it.src;
                pm_to[pm_total] = it.dst;
                pm_total++;
            end
            return;
        end
        pm_seen = '0;
        pm_fcount = 0;
        for (int i = 0; i < n; i++)
            if (!pm_seen[i]) g = dfs_walk(i, n, 0);
        pm_seen = '0;
        best = 0;
        best_set = '0;
        for (int k = pm_fcount; k > 0; k--) begin
            if (pm_seen[pm_finish[k-1]]) continue;
            g = dfs_walk(pm_finish[k-1], n, 1);
            if (g > best) begin
                best = g;
                best_set = '0;
                for (int j = 0; j < g; j++) best_set[pm_group[j]] = 1'b1;
            end
        end
        // Members leave in ascending order
        g = 0;
        for (int i = 0; i < 64; i++) begin
            if (best_set[i]) begin
                g++;
                m.member = i[5:0];
                m.size = best[6:0];
                m.last = (g == best);
                m.dropped = pm_drop;
                expected_members.push_back(m);
            end
        end
        pm_total = 0;
        pm_drop = 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: offer pending items, with random gaps
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || tx_done) begin
            tx_done = 0;
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_items[0].cmd;
                s_axis_tdata <= {4'b0, pending_items[0].dst, pending_items[0].src};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sender-side acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_component(pending_items.pop_front());
            items_accepted++;
            tx_gap = pick_gap();
            tx_done = 1;
        end
    end

    // Receiver readiness; long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_on) begin
            rx_ready_pick = pick_gap() == 0;
            m_axis_tready <= rx_ready_pick;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare every transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_member got;
        t_member want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.member = m_axis_tdata[5:0];
            got.size = m_axis_tdata[12:6];
            got.dropped = m_axis_tdata[13];
            got.last = m_axis_tlast;
            members_seen++;
            if (expected_members.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected member transfer %p", got);
            end else begin
                want = expected_members.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("member mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic add_edge(int s, int d);
        t_edge_item it;
        it.cmd = lsc_pkg::CMD_ADD_EDGE;
        it.src = s[5:0];
        it.dst = d[5:0];
        pending_items.push_back(it);
    endtask

    task automatic add_run();
        t_edge_item it;
        it.cmd = lsc_pkg::CMD_RUN;
        it.src = 6'($urandom);
        it.dst = 6'($urandom);
        pending_items.push_back(it);
        runs_sent++;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_members.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write node_count while the block is idle
    task automatic write_node_count(int n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n[6:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pm_nodes = n[6:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random graph of n nodes: a short ring plus random edges, some out of range
    task automatic random_graph(int n, int edges);
        int r;
        r = $urandom_range(2, (n < 8) ? n : 8);
        for (int i = 0; i < r; i++) add_edge(i, (i + 1) % r);
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 19) == 0) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
            else add_edge($urandom_range(0, n-1), $urandom_range(0, n-1));
        end
        add_run();
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        pm_total = 0;
        pm_drop = 1'b0;
        pm_nodes = 7'd64;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty run, extremes, a cycle, out of range endpoints
        add_run();
        add_edge(0, 63);
        add_edge(63, 0);
        add_edge(5, 5);
        add_run();
        add_edge(1, 2);
        add_edge(2, 3);
        add_edge(3, 1);
        add_edge(42, 21);
        add_edge(21, 42);
        add_edge(42, 63);
        add_run();
        drain();
        write_node_count(4);
        add_edge(0, 1);
        add_edge(1, 0);
        add_edge(2, 5);
        add_edge(63, 0);
        add_run();
        drain();
        write_node_count(1);
        add_edge(0, 0);
        add_edge(0, 1);
        add_run();
        drain();

        // Node count lowered after loading
        write_node_count(64);
        add_edge(0, 40);
        add_edge(40, 0);
        add_edge(2, 3);
        add_edge(3, 2);
        drain_cfg_lower();

        // Store overflow, with a long receiver hold-off once results start
        write_node_count(64);
        for (int i = 0; i < 64; i++) add_edge(i, (i + 1) % 64);
        for (int i = 0; i < 191; i++) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
        add_edge(1, 1);
        add_edge(2, 2);
        add_run();
        add_edge(7, 8);
        add_edge(8, 7);
        add_run();
        wait (m_axis_tvalid);
        hold_cycles = 400;
        drain();

        // Random phases with receiver stalls
        stall_on = 1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: n = 64;
                1: n = $urandom_range(2, 16);
                2: n = 0;
                default: n = $urandom_range(17, 127);
            endcase
            write_node_count(n);
            n = (n == 0) ? 1 : (n > 64 ? 64 : n);
            random_graph(n, $urandom_range(3, 8));
            drain();
        end
        stall_on = 0;
        drain();

        $display("Ran %0d items and %0d component searches; %0d members checked.",
                 items_accepted, runs_sent, members_seen);
        $display("Covered node counts 0..127, store overflow and output back-pressure.");
        if (mismatches == 0 && expected_members.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Lower the node count with edges still loaded, then run
    task automatic drain_cfg_lower();
        while (pending_items.size() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        write_node_count(10);
        add_run();
        drain();
    endtask

    // Limit
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
